// ===== sv/bloom_filter_fnv_double_hash_top_macros.svh =====
// Assertion macros for the bloom filter checker.
// Used only by the checker file; needs nothing else.
`ifndef BLOOM_FILTER_FNV_DOUBLE_HASH_TOP_MACROS_SVH
`define BLOOM_FILTER_FNV_DOUBLE_HASH_TOP_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define BFDH_ASSERT_SAME(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define BFDH_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== sv/bfdh_pkg.sv =====
// Shared constants for the bloom filter: FNV-1a values, seeds, mode and register codes.
// No dependencies.
package bfdh_pkg;

    localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
    localparam logic [63:0] SEED_ONE  = 64'hC6A4A7935BD1E995;
    localparam logic [63:0] SEED_TWO  = 64'h9AE16A3B2F90404F;
    localparam logic [63:0] HASH_ONE_INIT = FNV_BASIS ^ SEED_ONE;
    localparam logic [63:0] HASH_TWO_INIT = FNV_BASIS ^ SEED_TWO;

    localparam int MODE_W  = 2;
    localparam int COUNT_W = 6;
    localparam int LOG2_W  = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 6;

    localparam logic [COUNT_W-1:0] MAX_HASH_COUNT = 6'd32;
    localparam logic [LOG2_W-1:0]  MIN_BITS_LOG2  = 5'd6;

    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_HASH_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BITS_LOG2  = 2'd1;

endpackage

// ===== sv/bfdh_fnv_unit.sv =====
// Shared FNV-1a 64-bit fold: (hash xor byte) times the FNV prime.
// Depends on nothing; the prime 2^40 + 0x1B3 is built from shifts and adds.
module bfdh_fnv_unit (
    input  logic [63:0] hash_in,
    input  logic [7:0]  byte_in,
    output logic [63:0] hash_out
);

    logic [63:0] mixed;

    // Xor the byte in, then multiply by the sparse prime
    assign mixed = hash_in ^ {56'd0, byte_in};
    assign hash_out = mixed + (mixed << 1) + (mixed << 4) + (mixed << 5)
                    + (mixed << 7) + (mixed << 8) + (mixed << 40);

endmodule

// ===== sv/bfdh_bit_store.sv =====
// One-bit-wide filter store: one write port and one registered read port.
// No dependencies; contents are not reset (the sequencer sweeps it).
module bfdh_bit_store #(
    parameter int ADDR_W = 16
) (
    input  logic              clk,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic              rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic              wr_data
);

    logic mem [2**ADDR_W];

    // Write when enabled, read every cycle into the output register
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== sv/bloom_filter_fnv_double_hash_top.sv =====
// Bloom filter over a 2^MAX_BITS_LOG2 bit store with FNV-1a double hashing.
// Key byte: one shared fold unit does hash one, then hash two.
// Key end: per derived index a registered store read, then check/set (a query
// stops at its first clear bit), then the result post; hash_count 0 goes straight to it.
// Clear: sweeps the whole 2^MAX_BITS_LOG2 bit store, one store bit written per cycle.
// Reset: the same sweep of all 2^MAX_BITS_LOG2 bits runs with in_stall high.
module bloom_filter_fnv_double_hash_top
    import bfdh_pkg::*;
#(
    parameter int MAX_BITS_LOG2 = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [MODE_W-1:0]      mode,
    input  logic [7:0]             data_byte,
    input  logic                   has_byte,
    input  logic                   last,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   answer,
    output logic [MODE_W-1:0]      done_mode,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int ADDR_W = MAX_BITS_LOG2;
    localparam logic [ADDR_W-1:0] ADDR_LAST = {ADDR_W{1'b1}};

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_HASH2,
        S_READ,
        S_CHECK,
        S_CLEAR,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [63:0]         hash_one_reg, hash_one_next;
    logic [63:0]         hash_two_reg, hash_two_next;
    logic [7:0]          byte_reg, byte_next;
    logic                last_reg, last_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [ADDR_W-1:0]   acc_reg, acc_next;
    logic [COUNT_W-1:0]  step_reg, step_next;
    logic                flag_reg, flag_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic                out_valid_reg, out_valid_next;
    logic                answer_reg, answer_next;
    logic [MODE_W-1:0]   done_mode_reg, done_mode_next;

    logic [COUNT_W-1:0]  hash_count_reg;
    logic [LOG2_W-1:0]   bits_log2_reg;

    logic [COUNT_W-1:0]  count_eff;
    logic [LOG2_W-1:0]   log2_eff;
    logic [ADDR_W-1:0]   addr_mask;
    logic [ADDR_W-1:0]   bit_addr;

    logic [63:0]         fold_hash_in;
    logic [7:0]          fold_byte_in;
    logic [63:0]         fold_out;

    logic                rd_bit;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic                wr_data;

    logic                start_index;
    logic                finish;

    // Take configuration writes at any time
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_count_reg <= 6'd7;
            bits_log2_reg  <= 5'd16;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HASH_COUNT: hash_count_reg <= cfg_data;
                CFG_BITS_LOG2:  bits_log2_reg  <= cfg_data[LOG2_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturate the index count and clamp the store size in use
    assign count_eff = (hash_count_reg > MAX_HASH_COUNT) ? MAX_HASH_COUNT : hash_count_reg;

    always_comb
    begin
        if (bits_log2_reg < MIN_BITS_LOG2)
        begin
            log2_eff = MIN_BITS_LOG2;
        end
        else if (bits_log2_reg > LOG2_W'(MAX_BITS_LOG2))
        begin
            log2_eff = LOG2_W'(MAX_BITS_LOG2);
        end
        else
        begin
            log2_eff = bits_log2_reg;
        end
    end

    assign addr_mask = ~(ADDR_LAST << log2_eff);
    assign bit_addr  = acc_reg & addr_mask;

    // Share one fold unit between the two hashes
    assign fold_hash_in = (state_reg == S_HASH2) ? hash_two_reg : hash_one_reg;
    assign fold_byte_in = (state_reg == S_HASH2) ? byte_reg : data_byte;

    bfdh_fnv_unit u_fnv (
        .hash_in  (fold_hash_in),
        .byte_in  (fold_byte_in),
        .hash_out (fold_out)
    );

    bfdh_bit_store #(
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .rd_addr (bit_addr),
        .rd_data (rd_bit),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign answer    = answer_reg;
    assign done_mode = done_mode_reg;

    // Sequence bytes, index probes, clear sweeps and result posting
    always_comb
    begin
        state_next     = state_reg;
        hash_one_next  = hash_one_reg;
        hash_two_next  = hash_two_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        mode_next      = mode_reg;
        acc_next       = acc_reg;
        step_next      = step_reg;
        flag_next      = flag_reg;
        clr_addr_next  = clr_addr_reg;
        out_valid_next = out_valid_reg;
        answer_next    = answer_reg;
        done_mode_next = done_mode_reg;
        wr_en          = 1'b0;
        wr_addr        = bit_addr;
        wr_data        = 1'b0;
        start_index    = 1'b0;
        finish         = (step_reg == count_eff - 6'd1);

        // Drop a result once the consumer takes it
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (mode)
                        MODE_ADD, MODE_QUERY:
                        begin
                            mode_next = mode;
                            byte_next = data_byte;
                            last_next = last;
                            if (has_byte)
                            begin
                                hash_one_next = fold_out;
                                state_next    = S_HASH2;
                            end
                            else if (last)
                            begin
                                start_index = 1'b1;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            mode_next     = MODE_CLEAR;
                            clr_addr_next = '0;
                            flag_next     = 1'b0;
                            state_next    = S_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            S_HASH2:
            begin
                hash_two_next = fold_out;
                if (last_reg)
                begin
                    start_index = 1'b1;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!rd_bit)
                begin
                    if (mode_reg == MODE_ADD)
                    begin
                        wr_en     = 1'b1;
                        wr_data   = 1'b1;
                        flag_next = 1'b1;
                    end
                    else
                    begin
                        flag_next = 1'b0;
                        finish    = 1'b1;
                    end
                end
                acc_next   = acc_reg + hash_two_reg[ADDR_W-1:0];
                step_next  = step_reg + 6'd1;
                state_next = finish ? S_DONE : S_READ;
            end
            S_INIT, S_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_data       = 1'b0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_LAST)
                begin
                    state_next = (state_reg == S_INIT) ? S_IDLE : S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    answer_next    = flag_reg;
                    done_mode_next = mode_reg;
                    hash_one_next  = HASH_ONE_INIT;
                    hash_two_next  = HASH_TWO_INIT;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Start index derivation from the finished hashes
        if (start_index)
        begin
            acc_next   = hash_one_reg[ADDR_W-1:0];
            step_next  = '0;
            flag_next  = (mode_next == MODE_QUERY);
            state_next = (count_eff == '0) ? S_DONE : S_READ;
        end
    end

    // Hold state, working registers and the output transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            hash_one_reg  <= HASH_ONE_INIT;
            hash_two_reg  <= HASH_TWO_INIT;
            byte_reg      <= '0;
            last_reg      <= 1'b0;
            mode_reg      <= MODE_ADD;
            acc_reg       <= '0;
            step_reg      <= '0;
            flag_reg      <= 1'b0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            answer_reg    <= 1'b0;
            done_mode_reg <= MODE_ADD;
        end
        else
        begin
            state_reg     <= state_next;
            hash_one_reg  <= hash_one_next;
            hash_two_reg  <= hash_two_next;
            byte_reg      <= byte_next;
            last_reg      <= last_next;
            mode_reg      <= mode_next;
            acc_reg       <= acc_next;
            step_reg      <= step_next;
            flag_reg      <= flag_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            answer_reg    <= answer_next;
            done_mode_reg <= done_mode_next;
        end
    end

endmodule

// ===== sv/bfdh_checker.sv =====
// Port-level checks for the bloom filter top, attached by bind.
// Depends on bfdh_pkg and the assertion macro header.
`include "bloom_filter_fnv_double_hash_top_macros.svh"

module bfdh_checker
    import bfdh_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic [MODE_W-1:0] mode,
    input logic              last,
    input logic              out_valid,
    input logic              out_stall,
    input logic              answer,
    input logic [MODE_W-1:0] done_mode
);

    // A stalled result transaction holds
    `BFDH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(answer) && $stable(done_mode), "stalled result changed")

    // Results only carry add, query or clear
    `BFDH_ASSERT_SAME(a_mode_legal, clk, rst_n, out_valid, done_mode == MODE_ADD || done_mode == MODE_QUERY || done_mode == MODE_CLEAR, "result with unused mode")

    // A clear always answers zero
    `BFDH_ASSERT_SAME(a_clear_zero, clk, rst_n, out_valid && done_mode == MODE_CLEAR, !answer, "clear result answered one")

    // A clear or a key end blocks the next input while it works
    `BFDH_ASSERT_NEXT(a_clear_busy, clk, rst_n, in_valid && !in_stall && mode == MODE_CLEAR, in_stall, "input taken during clear")

    `BFDH_ASSERT_NEXT(a_key_busy, clk, rst_n, in_valid && !in_stall && (mode == MODE_ADD || mode == MODE_QUERY) && last, in_stall, "input taken during key end")

endmodule

bind bloom_filter_fnv_double_hash_top bfdh_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .answer    (answer),
    .done_mode (done_mode)
);
